// ----- rtl/tst_pkg.sv -----
package tst_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned SLOT_W = 7;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned TIME_W = 32;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_KILL = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_KILL = 2'd1,
    KIND_EXP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request word, restart scan
    logic adv;       // scan pipeline moves one slot
    logic emit_mid;  // push held expiry out, not last
    logic fin;       // commit and send final word
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] action;
    logic       chk_v;
    logic       chk_last;
    logic       hit;
    logic       pend_v;
    logic       out_free;
  } stat_t;

endpackage

// ----- rtl/tst_req_if.sv -----
interface tst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] timer_id;
  logic [31:0] delay_ms;
  logic [31:0] tag;

  modport source (output valid, output action, output timer_id, output delay_ms,
                  output tag, input ready);
  modport sink   (input valid, input action, input timer_id, input delay_ms,
                  input tag, output ready);
endinterface

// ----- rtl/tst_rsp_if.sv -----
interface tst_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ok;
  logic [6:0]  slot_number;
  logic [15:0] expired_id;
  logic [31:0] expired_tag;
  logic        last;

  modport source (output valid, output kind, output ok, output slot_number,
                  output expired_id, output expired_tag, output last, input ready);
  modport sink   (input valid, input kind, input ok, input slot_number,
                  input expired_id, input expired_tag, input last, output ready);
endinterface

// ----- rtl/timer_slot_table.sv -----
// Table of 64 one-shot millisecond timers. Every set, kill or tick word walks the
// whole slot table through its single read port, one slot per cycle unless a tick
// scan finds the next due timer while a held expiry waits on a stalled output. The
// next word is taken only once the walk is done and any final word of the item has
// gone into the output register, which also waits on a stalled output. Set and
// kill give one result; a tick gives one result
// per expired slot in slot order, the final one flagged last, and none if nothing
// is due. Action code three is accepted and dropped with no result. Slot contents
// come out of reset free through per-slot valid bits, so there is no clearing pass
// and the block is ready right after reset.
module timer_slot_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  tst_req_if.sink    req_i,
  tst_rsp_if.source  rsp_o
);

  tst_pkg::ctl_t  ctl;
  tst_pkg::stat_t stat;

  tst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_i.ready),
    .stat_i       (stat),
    .ctl_o        (ctl)
  );

  tst_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .action_i      (req_i.action),
    .timer_id_i    (req_i.timer_id),
    .delay_ms_i    (req_i.delay_ms),
    .tag_i         (req_i.tag),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .kind_o        (rsp_o.kind),
    .ok_o          (rsp_o.ok),
    .slot_number_o (rsp_o.slot_number),
    .expired_id_o  (rsp_o.expired_id),
    .expired_tag_o (rsp_o.expired_tag),
    .last_o        (rsp_o.last)
  );

  // only expiry runs produce words that are not last
  a_mid_is_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.last |-> rsp_o.kind == tst_pkg::KIND_EXP)
    else $error("non-last word is not an expiry");

  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ok |-> rsp_o.slot_number == '0)
    else $error("failed reply carries a slot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready &&
    (req_i.action == tst_pkg::ACT_SET || req_i.action == tst_pkg::ACT_KILL ||
     req_i.action == tst_pkg::ACT_TICK) |=> !req_i.ready)
    else $error("accepted a word while scanning");

  a_kill_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.kind == tst_pkg::KIND_KILL |-> rsp_o.expired_tag == '0)
    else $error("kill reply carries a tag");

endmodule

// ----- rtl/tst_ctrl.sv -----
module tst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic [1:0]      req_action_i,
  output logic            req_ready_o,
  input  tst_pkg::stat_t  stat_i,
  output tst_pkg::ctl_t   ctl_o
);

  tst_pkg::state_e state_q, state_d;

  logic is_tick;
  logic mid_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    ctl_o       = '0;
    is_tick     = (stat_i.action == tst_pkg::ACT_TICK);
    // a second expiry found while one is held: the held one must go out first
    mid_hit     = is_tick && stat_i.chk_v && stat_i.hit && stat_i.pend_v;
    case (state_q)
      tst_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        ctl_o.load  = req_valid_i;
        if (req_valid_i && (req_action_i inside {tst_pkg::ACT_SET, tst_pkg::ACT_KILL,
                                                 tst_pkg::ACT_TICK})) begin
          state_d = tst_pkg::ST_SCAN;
        end
      end
      tst_pkg::ST_SCAN: begin
        ctl_o.adv      = !(mid_hit && !stat_i.out_free);
        ctl_o.emit_mid = mid_hit && stat_i.out_free;
        if (stat_i.chk_v && stat_i.chk_last && ctl_o.adv) begin
          state_d = tst_pkg::ST_FIN;
        end
      end
      tst_pkg::ST_FIN: begin
        if (is_tick && !stat_i.pend_v) begin
          state_d = tst_pkg::ST_IDLE;       // tick with nothing due
        end else if (stat_i.out_free) begin
          ctl_o.fin = 1'b1;
          state_d   = tst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tst_dpath.sv -----
module tst_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tst_pkg::ctl_t                 ctl_i,
  output tst_pkg::stat_t                stat_o,
  input  logic [1:0]                    action_i,
  input  logic [tst_pkg::ID_W-1:0]      timer_id_i,
  input  logic [tst_pkg::TIME_W-1:0]    delay_ms_i,
  input  logic [tst_pkg::TAG_W-1:0]     tag_i,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic [1:0]                    kind_o,
  output logic                          ok_o,
  output logic [tst_pkg::SLOT_W-1:0]    slot_number_o,
  output logic [tst_pkg::ID_W-1:0]      expired_id_o,
  output logic [tst_pkg::TAG_W-1:0]     expired_tag_o,
  output logic                          last_o
);

  typedef struct packed {
    logic [tst_pkg::ID_W-1:0]   id;
    logic [tst_pkg::TAG_W-1:0]  tag;
    logic [tst_pkg::TIME_W-1:0] dl;
  } entry_t;

  // slot table; an entry whose valid bit is low counts as free
  entry_t mem [tst_pkg::SLOTS];
  entry_t rd_q;
  entry_t wr_data;

  logic [tst_pkg::SLOTS-1:0] valid_q;

  logic [1:0]                 act_q;
  logic [tst_pkg::ID_W-1:0]   id_q;
  logic [tst_pkg::TAG_W-1:0]  tag_q;
  logic [tst_pkg::TIME_W-1:0] dly_q;
  logic [tst_pkg::TIME_W-1:0] now_q;

  logic [tst_pkg::CNT_W-1:0] iss_q;
  logic [tst_pkg::IDX_W-1:0] chk_idx_q;
  logic                      chk_v_q;

  logic                      match_f_q, free_f_q;
  logic [tst_pkg::IDX_W-1:0] match_idx_q, free_idx_q;

  logic                      pend_v_q;
  logic [tst_pkg::IDX_W-1:0] pend_idx_q;
  logic [tst_pkg::ID_W-1:0]  pend_id_q;
  logic [tst_pkg::TAG_W-1:0] pend_tag_q;

  logic                       rsp_v_q;
  logic [1:0]                 kind_q;
  logic                       ok_q;
  logic [tst_pkg::SLOT_W-1:0] slot_q;
  logic [tst_pkg::ID_W-1:0]   xid_q;
  logic [tst_pkg::TAG_W-1:0]  xtag_q;
  logic                       last_q;

  logic                      rd_en, chk_en, chk_valid, hit, id_nz, out_free;
  logic                      found_set, found_kill, wr_en;
  logic [tst_pkg::IDX_W-1:0] sel_idx;

  assign rd_en     = ctl_i.adv && (iss_q < tst_pkg::CNT_W'(tst_pkg::SLOTS));
  assign chk_en    = ctl_i.adv && chk_v_q;
  assign chk_valid = valid_q[chk_idx_q];
  assign hit       = (act_q == tst_pkg::ACT_TICK) && chk_valid && (rd_q.dl != '0) &&
                     (now_q >= rd_q.dl);
  assign id_nz     = (id_q != '0);
  assign out_free  = !rsp_v_q || rsp_ready_i;
  assign sel_idx   = match_f_q ? match_idx_q : free_idx_q;
  assign found_set  = id_nz && (match_f_q || free_f_q);
  assign found_kill = id_nz && match_f_q;
  assign wr_en     = ctl_i.fin && (act_q == tst_pkg::ACT_SET) && found_set;

  always_comb begin
    wr_data.id  = id_q;
    wr_data.tag = tag_q;
    wr_data.dl  = now_q + dly_q;
  end

  always_comb begin
    stat_o.action   = act_q;
    stat_o.chk_v    = chk_v_q;
    stat_o.chk_last = (chk_idx_q == tst_pkg::IDX_W'(tst_pkg::SLOTS - 1));
    stat_o.hit      = hit;
    stat_o.pend_v   = pend_v_q;
    stat_o.out_free = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[sel_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[iss_q[tst_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      act_q <= action_i;
      id_q  <= timer_id_i;
      tag_q <= tag_i;
      dly_q <= delay_ms_i;
    end
    if (rd_en) begin
      chk_idx_q <= iss_q[tst_pkg::IDX_W-1:0];
    end
    if (chk_en) begin
      if (chk_valid && (rd_q.id == id_q) && !match_f_q) begin
        match_idx_q <= chk_idx_q;
      end
      if (!chk_valid && !free_f_q) begin
        free_idx_q <= chk_idx_q;
      end
      if (hit) begin
        pend_idx_q <= chk_idx_q;
        pend_id_q  <= rd_q.id;
        pend_tag_q <= rd_q.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= '0;
      iss_q     <= '0;
      chk_v_q   <= 1'b0;
      match_f_q <= 1'b0;
      free_f_q  <= 1'b0;
      pend_v_q  <= 1'b0;
      valid_q   <= '0;
    end else begin
      if (ctl_i.load) begin
        iss_q     <= '0;
        chk_v_q   <= 1'b0;
        match_f_q <= 1'b0;
        free_f_q  <= 1'b0;
        pend_v_q  <= 1'b0;
        if (action_i == tst_pkg::ACT_TICK) begin
          now_q <= now_q + tst_pkg::TIME_W'(1);
        end
      end else if (ctl_i.adv) begin
        chk_v_q <= rd_en;
        if (rd_en) begin
          iss_q <= iss_q + tst_pkg::CNT_W'(1);
        end
        if (chk_v_q) begin
          if (chk_valid && (rd_q.id == id_q)) begin
            match_f_q <= 1'b1;
          end
          if (!chk_valid) begin
            free_f_q <= 1'b1;
          end
          if (hit) begin
            valid_q[chk_idx_q] <= 1'b0;
            pend_v_q           <= 1'b1;
          end
        end
      end else if (ctl_i.fin) begin
        pend_v_q <= 1'b0;
        if (wr_en) begin
          valid_q[sel_idx] <= 1'b1;
        end
        if ((act_q == tst_pkg::ACT_KILL) && found_kill) begin
          valid_q[match_idx_q] <= 1'b0;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_v_q <= 1'b0;
    end else if (ctl_i.emit_mid || ctl_i.fin) begin
      rsp_v_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_mid) begin
      kind_q <= tst_pkg::KIND_EXP;
      ok_q   <= 1'b1;
      slot_q <= tst_pkg::SLOT_W'(pend_idx_q) + tst_pkg::SLOT_W'(1);
      xid_q  <= pend_id_q;
      xtag_q <= pend_tag_q;
      last_q <= 1'b0;
    end else if (ctl_i.fin) begin
      last_q <= 1'b1;
      case (act_q)
        tst_pkg::ACT_SET: begin
          kind_q <= tst_pkg::KIND_SET;
          ok_q   <= found_set;
          slot_q <= found_set ? tst_pkg::SLOT_W'(sel_idx) + tst_pkg::SLOT_W'(1) : '0;
          xid_q  <= id_q;
          xtag_q <= tag_q;
        end
        tst_pkg::ACT_KILL: begin
          kind_q <= tst_pkg::KIND_KILL;
          ok_q   <= found_kill;
          slot_q <= found_kill ? tst_pkg::SLOT_W'(match_idx_q) + tst_pkg::SLOT_W'(1) : '0;
          xid_q  <= id_q;
          xtag_q <= '0;
        end
        default: begin
          kind_q <= tst_pkg::KIND_EXP;
          ok_q   <= 1'b1;
          slot_q <= tst_pkg::SLOT_W'(pend_idx_q) + tst_pkg::SLOT_W'(1);
          xid_q  <= pend_id_q;
          xtag_q <= pend_tag_q;
        end
      endcase
    end
  end

  assign rsp_valid_o   = rsp_v_q;
  assign kind_o        = kind_q;
  assign ok_o          = ok_q;
  assign slot_number_o = slot_q;
  assign expired_id_o  = xid_q;
  assign expired_tag_o = xtag_q;
  assign last_o        = last_q;

endmodule
